// File: hw/rtl/wpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpq_pkg
// shared types and constants of the waypoint queue go-to-goal block
// ----------------------------------------------------------------------------
package wpq_pkg;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 24;

  localparam logic [CfgIdxBits-1:0] REG_ARRIVAL_RADIUS = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_DISTANCE_GAIN  = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_HEADING_GAIN   = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_LINEAR_LIMIT   = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_ANGULAR_LIMIT  = 3'd4;

  localparam int InBits = 1 + 24 + 24 + 16 + 13 + 12;
  localparam int InBytesBits = 96;
  localparam int OutBits = 15 + 16 + 1 + 1 + 12 + 12 + 4;
  localparam int OutBytesBits = 64;

  localparam int ZBits = 26;
  localparam logic signed [ZBits-1:0] PiQ20 = 26'sd3294199;

  // datapath angles, vectoring over 60-bit scaled errors
  localparam int CBits = 60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_SCALE,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic start_pose;
    logic add_point;
    logic sqrt_step;
    logic cordic_step;
    logic scale;
    logic clamp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic sqrt_done;
    logic cordic_done;
  } status_t;

  function automatic logic signed [ZBits-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZBits-1:0] r;
    begin
      case (i)
        5'd0: r = 26'sd823550;
        5'd1: r = 26'sd486170;
        5'd2: r = 26'sd256879;
        5'd3: r = 26'sd130396;
        5'd4: r = 26'sd65451;
        5'd5: r = 26'sd32757;
        5'd6: r = 26'sd16383;
        5'd7: r = 26'sd8192;
        5'd8: r = 26'sd4096;
        5'd9: r = 26'sd2048;
        5'd10: r = 26'sd1024;
        5'd11: r = 26'sd512;
        5'd12: r = 26'sd256;
        5'd13: r = 26'sd128;
        5'd14: r = 26'sd64;
        5'd15: r = 26'sd32;
        5'd16: r = 26'sd16;
        5'd17: r = 26'sd8;
        5'd18: r = 26'sd4;
        5'd19: r = 26'sd2;
        5'd20: r = 26'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: hw/rtl/wpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpq_ctrl
// sequencer: load, square root and cordic iterations, scale, clamp, output; add items go straight to output
// ----------------------------------------------------------------------------
module wpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  wpq_pkg::status_t  status,
  output wpq_pkg::cmd_t     cmd,
  output logic              busy
);

  wpq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wpq_pkg::ST_IDLE: begin
        if (in_fire) state_next = wpq_pkg::ST_SQRT;
      end
      wpq_pkg::ST_SQRT: begin
        if (status.is_add) state_next = wpq_pkg::ST_OUT;
        else if (status.sqrt_done) state_next = wpq_pkg::ST_CORDIC;
      end
      wpq_pkg::ST_CORDIC: begin
        if (status.cordic_done) state_next = wpq_pkg::ST_SCALE;
      end
      wpq_pkg::ST_SCALE: state_next = wpq_pkg::ST_CLAMP;
      wpq_pkg::ST_CLAMP: state_next = wpq_pkg::ST_OUT;
      wpq_pkg::ST_OUT: begin
        if (out_free) state_next = wpq_pkg::ST_IDLE;
      end
      default: state_next = wpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      wpq_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      wpq_pkg::ST_SQRT: begin
        cmd.add_point = status.is_add;
        cmd.sqrt_step = !status.is_add;
        cmd.start_pose = !status.is_add && status.sqrt_done;
      end
      wpq_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
      wpq_pkg::ST_SCALE: cmd.scale = 1'b1;
      wpq_pkg::ST_CLAMP: cmd.clamp = 1'b1;
      wpq_pkg::ST_OUT: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/wpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpq_datapath
// target queue, bit-pair square root, cordic atan2, gains and clamps
// ----------------------------------------------------------------------------
module wpq_datapath #(
  parameter int QUEUE_DEPTH = 10,
  parameter int COORD_BITS = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wpq_pkg::cmd_t                          cmd,
  output wpq_pkg::status_t                       status,
  input  logic [wpq_pkg::InBits-1:0]             in_item,
  input  logic [23:0]                            arrival_radius,
  input  logic [15:0]                            distance_gain,
  input  logic [15:0]                            heading_gain,
  input  logic [14:0]                            linear_limit,
  input  logic [14:0]                            angular_limit,
  output logic [wpq_pkg::OutBits-1:0]            out_item
);

  localparam int IdxBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam int EBits = ((COORD_BITS + 8 > 24) ? COORD_BITS + 8 : 24) + 2;
  localparam int SBits = 2 * EBits + 2;
  localparam int RBits = EBits + 2;
  localparam int StepBits = 6;
  localparam int CB = wpq_pkg::CBits;

  logic [2*COORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [IdxBits-1:0] head_index;
  logic [CntBits-1:0] target_count;
  logic [2*COORD_BITS-1:0] head_word;

  logic req_type;
  logic signed [23:0] pose_x, pose_y;
  logic signed [15:0] heading;
  logic [12:0] point_x;
  logic [11:0] point_y;

  logic signed [EBits-1:0] ex, ey;
  logic [SBits-1:0] sq_rem, sq_root, sq_bit;
  logic [StepBits-1:0] step;
  logic signed [CB-1:0] cx, cy;
  logic signed [wpq_pkg::ZBits-1:0] cz;
  logic cordic_zero;
  logic [RBits-1:0] dist_q;
  logic is_arrived, accepted;
  logic [RBits+15:0] lin_prod;
  logic signed [16:0] err;
  logic signed [33:0] ang_prod;
  logic [14:0] lin_out;
  logic signed [15:0] ang_out;
  logic [2*EBits-1:0] ex2, ey2;
  logic [IdxBits-1:0] tail;
  logic [CntBits+IdxBits:0] tail_sum;

  assign {point_y, point_x, heading, pose_y, pose_x, req_type} = in_item;

  always_ff @(posedge clk) begin
    if (rst) mem[0] <= {COORD_BITS'(20), COORD_BITS'(20)};
    else if (cmd.add_point && accepted) mem[tail] <= {COORD_BITS'(point_x),
      COORD_BITS'(point_y)};
  end

  assign head_word = mem[head_index];
  assign tail_sum = (CntBits + IdxBits + 1)'(head_index) + (CntBits + IdxBits + 1)'(target_count);
  assign tail = (tail_sum >= (CntBits + IdxBits + 1)'(QUEUE_DEPTH))
    ? IdxBits'(tail_sum - (CntBits + IdxBits + 1)'(QUEUE_DEPTH)) : IdxBits'(tail_sum);

  assign ex2 = (2 * EBits)'(ex * ex);
  assign ey2 = (2 * EBits)'(ey * ey);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      target_count <= CntBits'(1);
      accepted <= 1'b0;
      is_arrived <= 1'b0;
    end else begin
      if (cmd.load) begin
        accepted <= req_type && (point_x != 13'h1FFF)
          && (target_count < CntBits'(QUEUE_DEPTH));
        is_arrived <= 1'b0;
      end
      if (cmd.add_point && accepted) target_count <= target_count + 1'b1;
      if (cmd.start_pose && (RBits'(sq_root) < RBits'(arrival_radius))) begin
        is_arrived <= 1'b1;
        if (target_count > CntBits'(1)) begin
          target_count <= target_count - 1'b1;
          head_index <= (head_index == IdxBits'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ex <= EBits'($signed({2'b0, head_word[2*COORD_BITS-1:COORD_BITS], 8'd0}))
        - EBits'(pose_x);
      ey <= EBits'($signed({2'b0, head_word[COORD_BITS-1:0], 8'd0}))
        - EBits'(pose_y);
      sq_root <= '0;
      sq_bit <= SBits'(1) << (SBits - 2);
      step <= '0;
      sq_rem <= '0;
    end else if (cmd.sqrt_step) begin
      if (step == '0) begin
        sq_rem <= SBits'(ex2) + SBits'(ey2);
        step <= step + 1'b1;
      end else if (sq_bit != '0) begin
        if (sq_rem >= sq_root + sq_bit) begin
          sq_rem <= sq_rem - (sq_root + sq_bit);
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
    end
    if (cmd.start_pose) begin
      dist_q <= RBits'(sq_root);
      step <= '0;
      cordic_zero <= (ex == '0) && (ey == '0);
      if (ex < 0) begin
        cx <= -(CB'(ex) <<< 16);
        cy <= -(CB'(ey) <<< 16);
        cz <= (ey >= 0) ? wpq_pkg::PiQ20 : -wpq_pkg::PiQ20;
      end else begin
        cx <= CB'(ex) <<< 16;
        cy <= CB'(ey) <<< 16;
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (cy >= 0) begin
        cx <= cx + (cy >>> step);
        cy <= cy - (cx >>> step);
        cz <= cz + wpq_pkg::atan_q20(step[4:0]);
      end else begin
        cx <= cx - (cy >>> step);
        cy <= cy + (cx >>> step);
        cz <= cz - wpq_pkg::atan_q20(step[4:0]);
      end
      step <= step + 1'b1;
    end
    if (cmd.scale) begin
      lin_prod <= (RBits + 16)'(dist_q) * (RBits + 16)'(distance_gain);
      err <= (cordic_zero ? 17'sd0 : 17'($signed(cz + 26'sd128) >>> 8)) - 17'(heading);
    end
    if (cmd.clamp) begin
      lin_out <= ((lin_prod >> 8) > (RBits + 16)'(linear_limit)) ? linear_limit
        : 15'(lin_prod >> 8);
    end
  end

  assign ang_prod = 34'(err) * $signed({18'd0, heading_gain});

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      if ((ang_prod >>> 12) > $signed({19'd0, angular_limit}))
        ang_out <= 16'(angular_limit);
      else if ((ang_prod >>> 12) < -$signed({19'd0, angular_limit}))
        ang_out <= -16'(angular_limit);
      else
        ang_out <= 16'(ang_prod >>> 12);
    end
  end

  assign status.is_add = req_type;
  assign status.sqrt_done = (step != '0) && (sq_bit == '0);
  assign status.cordic_done = step == StepBits'(CORDIC_STEPS - 1);

  assign out_item = {4'(target_count), 12'(head_word[COORD_BITS-1:0]),
    12'(head_word[2*COORD_BITS-1:COORD_BITS]), accepted && req_type,
    is_arrived && !req_type,
    (req_type || is_arrived) ? 16'd0 : ang_out,
    (req_type || is_arrived) ? 15'd0 : lin_out};

endmodule

// File: hw/rtl/waypoint_queue_go_to_goal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_queue_go_to_goal
// waypoint fifo with proportional go-to-goal drive command
// pose item: sum of squares, 27 sqrt steps, CORDIC_STEPS cordic steps, scale, clamp, then the result
// add-target item: the queue write, then the result; one item at a time
// next input in the cycle after the result is registered
// synchronous reset restores the single target (20,20) and register defaults
// ----------------------------------------------------------------------------
module waypoint_queue_go_to_goal #(
  parameter int QUEUE_DEPTH = 10,
  parameter int COORD_BITS = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // req_type, pose_x, pose_y, heading, point_x, point_y
  input  logic [wpq_pkg::InBytesBits-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // lin_cmd, ang_cmd, arrived, point_accepted, head_x, head_y, queue_count
  output logic [wpq_pkg::OutBytesBits-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [wpq_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [wpq_pkg::CfgDataBits-1:0]     cfg_data
);

  logic [23:0] arrival_radius;
  logic [15:0] distance_gain, heading_gain;
  logic [14:0] linear_limit, angular_limit;
  logic [wpq_pkg::InBits-1:0] in_reg;
  logic [wpq_pkg::OutBits-1:0] res;
  wpq_pkg::cmd_t cmd;
  wpq_pkg::status_t status;
  logic busy, in_fire, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_radius <= 24'd1280;
      distance_gain <= 16'd4096;
      heading_gain <= 16'd8192;
      linear_limit <= 15'd8192;
      angular_limit <= 15'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        wpq_pkg::REG_ARRIVAL_RADIUS: arrival_radius <= cfg_data;
        wpq_pkg::REG_DISTANCE_GAIN: distance_gain <= cfg_data[15:0];
        wpq_pkg::REG_HEADING_GAIN: heading_gain <= cfg_data[15:0];
        wpq_pkg::REG_LINEAR_LIMIT: linear_limit <= cfg_data[14:0];
        wpq_pkg::REG_ANGULAR_LIMIT: angular_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (in_fire) in_reg <= s_tdata[wpq_pkg::InBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) m_tdata <= {{(wpq_pkg::OutBytesBits - wpq_pkg::OutBits){1'b0}}, res};
  end

  wpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy)
  );

  wpq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_item(cmd.load ? s_tdata[wpq_pkg::InBits-1:0] : in_reg),
    .arrival_radius(arrival_radius), .distance_gain(distance_gain),
    .heading_gain(heading_gain), .linear_limit(linear_limit),
    .angular_limit(angular_limit), .out_item(res)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the waypoint queue go-to-goal block: directed queue and pose
// cases, then random waypoint and pose traffic under several register
// settings, with random gaps and stalls on both stream sides, checked
// field by field against a predictor of the queue and the drive command
// ----------------------------------------------------------------------------
module tb;

  localparam int Depth = 10;
  localparam int Steps = 16;
  localparam longint CycleLimit = 3000000;
  localparam logic [12:0] InvalidX = 13'h1FFF;

  typedef struct {
    bit                 is_add;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] hd;
    logic [12:0]        ptx;
    logic [11:0]        pty;
  } req_t;

  typedef struct {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic               arr;
    logic               acc;
    logic [11:0]        hx;
    logic [11:0]        hy;
    logic [3:0]         cnt;
  } cmd_res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [wpq_pkg::InBytesBits-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [wpq_pkg::OutBytesBits-1:0] m_tdata;
  logic cfg_we = 0;
  logic [wpq_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [wpq_pkg::CfgDataBits-1:0] cfg_data = '0;

  waypoint_queue_go_to_goal u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [11:0] wp_x [Depth];
  logic [11:0] wp_y [Depth];
  int unsigned wp_head;
  int unsigned wp_count;
  longint unsigned radius, dist_gain, head_gain, lin_lim, ang_lim;
  longint atan_tab [Steps] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                               8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  cmd_res_t expected_cmds [$];
  int errors = 0;
  int n_pose = 0, n_add = 0, n_arrived = 0, n_accepted = 0, n_checked = 0;
  int n_settings = 1;
  longint cycles = 0;
  bit hold_req = 0;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint heading_q12(longint ey, longint ex);
    longint x, y, z, dx, dy;
    if (ex == 0 && ey == 0) return 0;
    x = ex * 65536;
    y = ey * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 3294199 : -3294199;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic cmd_res_t drive_command(req_t r);
    cmd_res_t o;
    longint ex, ey, err, a;
    longint unsigned d, l;
    o = '{default: '0};
    if (r.is_add) begin
      if (r.ptx != InvalidX && wp_count < Depth) begin
        wp_x[(wp_head + wp_count) % Depth] = r.ptx[11:0];
        wp_y[(wp_head + wp_count) % Depth] = r.pty;
        wp_count++;
        o.acc = 1;
      end
    end else begin
      ex = longint'(wp_x[wp_head]) * 256 - longint'(r.px);
      ey = longint'(wp_y[wp_head]) * 256 - longint'(r.py);
      d = int_sqrt(ex * ex + ey * ey);
      if (d < radius) begin
        o.arr = 1;
        if (wp_count > 1) begin
          wp_head = (wp_head + 1) % Depth;
          wp_count--;
        end
      end else begin
        l = (d * dist_gain) >> 8;
        if (l > lin_lim) l = lin_lim;
        o.lin = l[14:0];
        err = heading_q12(ey, ex) - longint'(r.hd);
        a = (err * longint'(head_gain)) >>> 12;
        if (a > longint'(ang_lim)) a = ang_lim;
        if (a < -longint'(ang_lim)) a = -longint'(ang_lim);
        o.ang = a[15:0];
      end
    end
    o.hx = wp_x[wp_head];
    o.hy = wp_y[wp_head];
    o.cnt = wp_count[3:0];
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
  endtask

  // result checker
  always @(posedge clk) begin
    cmd_res_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cmds.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        w = expected_cmds.pop_front();
        if (m_tdata[14:0] !== w.lin) report("lin_cmd", m_tdata[14:0], w.lin);
        if (m_tdata[30:15] !== w.ang)
          report("ang_cmd", $signed(m_tdata[30:15]), w.ang);
        if (m_tdata[31] !== w.arr) report("arrived", m_tdata[31], w.arr);
        if (m_tdata[32] !== w.acc) report("point_accepted", m_tdata[32], w.acc);
        if (m_tdata[44:33] !== w.hx) report("head_x", m_tdata[44:33], w.hx);
        if (m_tdata[56:45] !== w.hy) report("head_y", m_tdata[56:45], w.hy);
        if (m_tdata[60:57] !== w.cnt) report("queue_count", m_tdata[60:57], w.cnt);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[waypoint_queue_go_to_goal] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        hold_req = 0;
        m_tready <= 1;
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_tready <= 0;
          repeat (n - 1) @(negedge clk);
        end else begin
          m_tready <= 1;
        end
      end
    end
  end

  task automatic send_item(req_t r, bit gaps);
    int g;
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {6'b0, r.pty, r.ptx, r.hd, r.py, r.px, r.is_add};
    do @(posedge clk); while (!s_tready);
    expected_cmds.insert(expected_cmds.size(), drive_command(r));
    if (r.is_add) n_add++; else n_pose++;
    if (expected_cmds[$].arr) n_arrived++;
    if (expected_cmds[$].acc) n_accepted++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_pose(longint x, longint y, longint h, bit gaps = 1);
    req_t r;
    r = '{is_add: 0, px: x[23:0], py: y[23:0], hd: h[15:0],
          ptx: 13'($urandom), pty: 12'($urandom)};
    send_item(r, gaps);
  endtask

  task automatic send_point(logic [12:0] x, logic [11:0] y, bit gaps = 1);
    req_t r;
    r = '{is_add: 1, px: 24'($urandom), py: 24'($urandom), hd: 16'($urandom),
          ptx: x, pty: y};
    send_item(r, gaps);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [wpq_pkg::CfgIdxBits-1:0] idx, longint unsigned v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[23:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      wpq_pkg::REG_ARRIVAL_RADIUS: radius = v & 24'hFFFFFF;
      wpq_pkg::REG_DISTANCE_GAIN:  dist_gain = v & 16'hFFFF;
      wpq_pkg::REG_HEADING_GAIN:   head_gain = v & 16'hFFFF;
      wpq_pkg::REG_LINEAR_LIMIT:   lin_lim = v & 15'h7FFF;
      wpq_pkg::REG_ANGULAR_LIMIT:  ang_lim = v & 15'h7FFF;
      default: ;
    endcase
  endtask

  task automatic set_all(longint unsigned r, longint unsigned dg, longint unsigned hg,
                         longint unsigned ll, longint unsigned al);
    wait_idle();
    write_reg(wpq_pkg::REG_ARRIVAL_RADIUS, r);
    write_reg(wpq_pkg::REG_DISTANCE_GAIN, dg);
    write_reg(wpq_pkg::REG_HEADING_GAIN, hg);
    write_reg(wpq_pkg::REG_LINEAR_LIMIT, ll);
    write_reg(wpq_pkg::REG_ANGULAR_LIMIT, al);
    n_settings++;
  endtask

  task automatic pose_near(int spread);
    longint x, y;
    x = longint'(wp_x[wp_head]) * 256 + $urandom_range(0, 2 * spread) - spread;
    y = longint'(wp_y[wp_head]) * 256 + $urandom_range(0, 2 * spread) - spread;
    send_pose(x, y, $signed(16'($urandom)));
  endtask

  task automatic test_queue_directed();
    send_pose(20 * 256, 20 * 256, 0);
    send_point(InvalidX, 12'd7);
    send_point(13'd4095, 12'd4095);
    send_point(13'd0, 12'd0);
    send_point(13'h1FFB, 12'd100);
    for (int i = 0; i < 7; i++) send_point(13'(i * 500), 12'(i * 600), 0);
    send_point(13'd1, 12'd1);
    for (int i = 0; i < 3; i++) send_pose(longint'(wp_x[wp_head]) * 256,
                                          longint'(wp_y[wp_head]) * 256, 0);
  endtask

  task automatic test_pose_directed();
    send_pose(-8388608, 8388607, 32767);
    send_pose(8388607, -8388608, -32768);
    send_pose(-8388608, -8388608, 0);
    send_pose(8388607, 8388607, 0, 0);
    send_pose(0, 0, -32768, 0);
    set_all(0, 65535, 65535, 32767, 32767);
    send_pose(longint'(wp_x[wp_head]) * 256, longint'(wp_y[wp_head]) * 256, 100);
    send_pose(-8388608, 0, 32767);
    send_pose(8388607, 1, -32768);
  endtask

  task automatic test_random(int n_items);
    int kind;
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 9) == 0) send_point(InvalidX, 12'($urandom));
        else if ($urandom_range(0, 9) == 0) send_point(13'($urandom), 12'($urandom));
        else send_point(13'($urandom_range(0, 4095)), 12'($urandom));
      end else if (kind < 80) begin
        pose_near($urandom_range(0, 1) ? int'(radius) + 200 : 20000);
      end else begin
        send_pose($signed(24'($urandom)), $signed(24'($urandom)), $signed(16'($urandom)));
      end
    end
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_req = 1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_point(13'($urandom_range(0, 4095)), 12'($urandom), 0);
      else pose_near(3000);
    end
  endtask

  task automatic test_config_sweep();
    set_all(0, 0, 0, 0, 0);
    test_random(60);
    set_all(24'hFFFFFF, 65535, 65535, 32767, 32767);
    test_random(60);
    for (int p = 0; p < 5; p++) begin
      set_all($urandom_range(0, 6000), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 32767), $urandom_range(0, 32767));
      test_random(300);
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      wp_x[i] = 0;
      wp_y[i] = 0;
    end
    wp_x[0] = 20;
    wp_y[0] = 20;
    wp_head = 0;
    wp_count = 1;
    radius = 1280;
    dist_gain = 4096;
    head_gain = 8192;
    lin_lim = 8192;
    ang_lim = 8192;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    test_queue_directed();
    test_pose_directed();
    set_all(1280, 4096, 8192, 8192, 8192);
    test_random(200);
    test_backpressure();
    test_config_sweep();

    wait_idle();
    $display("covered %0d pose and %0d waypoint transfers, %0d results checked",
             n_pose, n_add, n_checked);
    $display("%0d arrivals, %0d waypoints queued, %0d register settings",
             n_arrived, n_accepted, n_settings);
    if (errors == 0) begin
      $display("[waypoint_queue_go_to_goal] OK");
    end else begin
      $display("[waypoint_queue_go_to_goal] ERROR");
    end
    $finish;
  end

endmodule
